[sv/tpm_pkg.sv]
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants of the trapezoidal motion unit
// Holds the configuration record, the register map and the Q16.16 format.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int unsigned QShift    = 16;
  localparam int unsigned DataW     = 32;
  localparam int unsigned StepW     = 17;
  localparam int unsigned AccelW    = 31;
  localparam int unsigned PaddrW    = 5;
  localparam int unsigned RegIdxW   = 3;

  // Register indexes (byte address is four times the index).
  localparam logic [RegIdxW-1:0] RegPathLength  = 3'd0;
  localparam logic [RegIdxW-1:0] RegAccelRate   = 3'd1;
  localparam logic [RegIdxW-1:0] RegDecelRate   = 3'd2;
  localparam logic [RegIdxW-1:0] RegTopSpeed    = 3'd3;
  localparam logic [RegIdxW-1:0] RegFloorSpeed  = 3'd4;
  localparam logic [RegIdxW-1:0] RegBrakingDist = 3'd5;

  typedef struct packed {
    logic [DataW-1:0]  path_length;
    logic [AccelW-1:0] accel_rate;
    logic [DataW-1:0]  decel_rate;
    logic [DataW-1:0]  top_speed;
    logic [DataW-1:0]  floor_speed;
    logic [DataW-1:0]  braking_distance;
  } cfg_t;

endpackage

[sv/tpm_qmul.sv]
// ----------------------------------------------------------------------------
// tpm_qmul: shared Q16.16 multiplier with saturation
// Multiplies a 32-bit operand by the 17-bit time step, drops 16 fraction
// bits and saturates to 32 bits; the result is registered.
// ----------------------------------------------------------------------------
module tpm_qmul
  import tpm_pkg::*;
(
  input  logic             clk_i,
  input  logic [DataW-1:0] a_i,
  input  logic [StepW-1:0] b_i,
  output logic [DataW-1:0] p_o
);

  logic [DataW+StepW-1:0] full;
  logic [DataW:0]         scaled;
  logic [DataW-1:0]       p_d, p_q;

  assign full   = {{StepW{1'b0}}, a_i} * {{DataW{1'b0}}, b_i};
  assign scaled = full[DataW+QShift:QShift];
  assign p_d    = scaled[DataW] ? {DataW{1'b1}} : scaled[DataW-1:0];

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

[sv/tpm_regs.sv]
// ----------------------------------------------------------------------------
// tpm_regs: configuration register bank
// APB-style slave holding the six motion parameters; always ready.
// ----------------------------------------------------------------------------
module tpm_regs
  import tpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t             cfg_q;
  logic             wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[PaddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        RegPathLength:  cfg_q.path_length      <= pwdata;
        RegAccelRate:   cfg_q.accel_rate       <= pwdata[AccelW-1:0];
        RegDecelRate:   cfg_q.decel_rate       <= pwdata;
        RegTopSpeed:    cfg_q.top_speed        <= pwdata;
        RegFloorSpeed:  cfg_q.floor_speed      <= pwdata;
        RegBrakingDist: cfg_q.braking_distance <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegPathLength:  prdata = cfg_q.path_length;
      RegAccelRate:   prdata = {1'b0, cfg_q.accel_rate};
      RegDecelRate:   prdata = cfg_q.decel_rate;
      RegTopSpeed:    prdata = cfg_q.top_speed;
      RegFloorSpeed:  prdata = cfg_q.floor_speed;
      RegBrakingDist: prdata = cfg_q.braking_distance;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[sv/trapezoidal_ping_pong_motion_unit.sv]
// ----------------------------------------------------------------------------
// trapezoidal_ping_pong_motion_unit: trapezoidal velocity profile, ping-pong
// Moves a point back and forth along a straight Q16.16 path, one tick per
// request, with acceleration, cruise and braking phases.
// ----------------------------------------------------------------------------
// Each input request carries a time step and produces exactly one result:
// position along the path, distance moved this tick, the new velocity, the
// current leg direction and an arrival flag. From acceptance a request runs
// through EVAL, MUL1, VUPD, MUL2, MOVE and OUT to the result register: one
// shared 32x17 saturating multiplier is used twice in sequence (velocity
// change, then distance), and the state updates between the two products
// depend on each other. With nothing left to go EVAL skips to OUT, and with
// the velocity zero MOVE is skipped, since the second product is not needed.
// The request side opens as the result register is loaded, so a new request
// waits until the previous one has left the sequencer; in_stall_o is high
// while a request is in flight. A finished result sits in an output register
// until taken, and the next request may be accepted while it waits; that
// request then holds in its last step until the previous result is taken.
// Configuration registers are written through the APB-style port at byte
// addresses 0, 4, ... 20 and must only be changed while the unit is idle.
module trapezoidal_ping_pong_motion_unit
  import tpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // Request channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [StepW-1:0]  time_step_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DataW-1:0]  axis_position_o,
  output logic [DataW-1:0]  step_taken_o,
  output logic [DataW-1:0]  speed_now_o,
  output logic              reversed_o,
  output logic              arrived_o
);

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_VUPD = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_MOVE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  cfg_t cfg;

  tpm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e           state_q, state_d;
  logic [DataW-1:0] vel_q, vel_d;
  logic [DataW-1:0] done_q, done_d;
  logic [DataW-1:0] pos_q, pos_d;
  logic             rev_q, rev_d;
  logic [StepW-1:0] dt_q;
  logic [DataW-1:0] left_q;
  logic             acc_q, dec_q;
  logic [DataW-1:0] step_q, step_d;
  logic             hit_q, hit_d;

  logic             out_valid_q;
  logic [DataW-1:0] out_pos_q, out_step_q, out_vel_q;
  logic             out_rev_q, out_hit_q;

  // Shared multiplier: operand A is chosen by the sequencer, B is the step.
  logic [DataW-1:0] mul_a, mul_p;
  logic [DataW-1:0] decel_mag;

  // Two's complement magnitude; the most negative value maps to itself.
  assign decel_mag = (~cfg.decel_rate) + 32'd1;

  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = acc_q ? {1'b0, cfg.accel_rate} : decel_mag;
    end else begin
      mul_a = vel_q;
    end
  end

  tpm_qmul u_qmul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (dt_q),
    .p_o   (mul_p)
  );

  // Velocity update helpers: capped sum when speeding up, floored
  // difference when braking.
  logic [DataW:0]   acc_sum;
  logic [DataW-1:0] brake_gap;
  logic [DataW-1:0] step_clamped;
  logic [DataW-1:0] done_sum;

  assign acc_sum      = {1'b0, vel_q} + {1'b0, mul_p};
  assign brake_gap    = vel_q - cfg.floor_speed;
  assign step_clamped = (mul_p > left_q) ? left_q : mul_p;
  assign done_sum     = done_q + step_clamped;

  logic in_fire, out_free;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    vel_d   = vel_q;
    done_d  = done_q;
    pos_d   = pos_q;
    rev_d   = rev_q;
    step_d  = step_q;
    hit_d   = hit_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        step_d = '0;
        hit_d  = 1'b0;
        // Nothing left to go leaves the state untouched.
        state_d = (done_q < cfg.path_length) ? S_MUL1 : S_OUT;
      end
      S_MUL1: begin
        state_d = S_VUPD;
      end
      S_VUPD: begin
        if (acc_q) begin
          vel_d = (acc_sum > {1'b0, cfg.top_speed}) ? cfg.top_speed : acc_sum[DataW-1:0];
        end else if (dec_q) begin
          vel_d = (mul_p >= brake_gap) ? cfg.floor_speed : vel_q - mul_p;
        end
        state_d = S_MUL2;
      end
      S_MUL2: begin
        // Standing still means no move this tick.
        state_d = (vel_q != '0) ? S_MOVE : S_OUT;
      end
      S_MOVE: begin
        step_d = step_clamped;
        pos_d  = rev_q ? pos_q - step_clamped : pos_q + step_clamped;
        if (done_sum >= cfg.path_length) begin
          vel_d  = '0;
          done_d = '0;
          rev_d  = ~rev_q;
          hit_d  = 1'b1;
        end else begin
          done_d = done_sum;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vel_q       <= '0;
      done_q      <= '0;
      pos_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vel_q   <= vel_d;
      done_q  <= done_d;
      pos_q   <= pos_d;
      rev_q   <= rev_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-request working registers and the result register.
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    hit_q  <= hit_d;
    if (in_fire) begin
      dt_q <= time_step_i;
    end
    if (state_q == S_EVAL) begin
      left_q <= cfg.path_length - done_q;
      acc_q  <= (cfg.accel_rate != '0) && (vel_q < cfg.top_speed) &&
                ((cfg.path_length - done_q) > cfg.braking_distance);
      dec_q  <= cfg.decel_rate[DataW-1] && (vel_q > cfg.floor_speed) &&
                ((cfg.path_length - done_q) <= cfg.braking_distance);
    end
    if (state_q == S_OUT && out_free) begin
      out_pos_q  <= pos_q;
      out_step_q <= step_q;
      out_vel_q  <= vel_q;
      out_rev_q  <= rev_q;
      out_hit_q  <= hit_q;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign axis_position_o = out_pos_q;
  assign step_taken_o    = out_step_q;
  assign speed_now_o     = out_vel_q;
  assign reversed_o      = out_rev_q;
  assign arrived_o       = out_hit_q;

endmodule
